@@ sv/mpwm_pkg.sv @@
// Shared types and constants for the multichannel PWM scheduler.
`default_nettype none
package mpwm_pkg;

    localparam int CHANNELS = 11;
    localparam int ACT_CH   = CHANNELS - 1;
    localparam int IDXW     = $clog2(CHANNELS);

    localparam int OP_W   = 2;
    localparam int CH_W   = 4;
    localparam int DUTY_W = 8;
    localparam int MODE_W = 2;

    localparam int S_TDATA_W = ((CH_W + DUTY_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((CHANNELS + DUTY_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_PERIOD = 2'd1;
    localparam logic [OP_W-1:0] OP_MATCH  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_BREATH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ON     = 2'd1;

    localparam logic [DUTY_W-1:0] NO_MATCH      = 8'd255;
    localparam logic [DUTY_W-1:0] DUTY_OFF      = 8'd0;
    localparam logic [DUTY_W-1:0] BREATH_TOP    = 8'd254;
    localparam logic [DUTY_W-1:0] BREATH_BOTTOM = 8'd2;
    localparam logic [DUTY_W-1:0] BREATH_DARK   = 8'd20;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CH_W-1:0]   ch;
        logic [DUTY_W-1:0] duty;
    } cmd_t;

    typedef struct packed {
        logic [CHANNELS-1:0] pins;
        logic [DUTY_W-1:0]   cmp;
    } res_t;

endpackage
`default_nettype wire

@@ sv/mpwm_breath.sv @@
// Breathing ramp generator for the activity channel.
`default_nettype none
module mpwm_breath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    output logic [mpwm_pkg::DUTY_W-1:0]      level
);
    import mpwm_pkg::*;

    logic [DUTY_W-1:0] level_reg;
    logic              falling_reg;
    logic [DUTY_W-1:0] level_next;
    logic              falling_next;

    // Hide the dim end of the ramp.
    assign level = (level_reg > BREATH_DARK) ? level_reg : DUTY_OFF;

    always_comb
    begin
        level_next   = falling_reg ? level_reg - 8'd1 : level_reg + 8'd1;
        falling_next = falling_reg;
        if (level_next >= BREATH_TOP)
        begin
            falling_next = 1'b1;
        end
        else if (level_next <= BREATH_BOTTOM)
        begin
            falling_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg   <= '0;
            falling_reg <= 1'b0;
        end
        else if (step)
        begin
            level_reg   <= level_next;
            falling_reg <= falling_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/mpwm_core.sv @@
// Event sequencer with one shared per-channel compare/minimum unit.
`default_nettype none
module mpwm_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire mpwm_pkg::cmd_t               cmd,
    input  wire logic [mpwm_pkg::MODE_W-1:0]  mode,
    output logic                              ready,
    output logic                              res_valid,
    input  wire logic                         res_take,
    output mpwm_pkg::res_t                    res
);
    import mpwm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic [DUTY_W-1:0]   staged_reg [CHANNELS];
    logic [DUTY_W-1:0]   active_reg [CHANNELS];
    logic [CHANNELS-1:0] pins_reg;
    logic [DUTY_W-1:0]   cmp_reg;
    logic [DUTY_W-1:0]   min_reg;
    logic [IDXW-1:0]     idx_reg;
    logic                period_reg;

    logic [DUTY_W-1:0]   breath_level;
    logic                breath_step;

    logic [DUTY_W-1:0]   cur_val;
    logic                kill;
    logic                pin_val;
    logic [DUTY_W-1:0]   new_val;
    logic [DUTY_W-1:0]   scan_min;
    logic [IDXW-1:0]     wr_idx;

    assign breath_step = (state_reg == ST_IDLE) && start && (cmd.op == OP_PERIOD)
                         && (mode == MODE_BREATH);

    mpwm_breath u_breath (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (breath_step),
        .level (breath_level)
    );

    assign wr_idx = IDXW'(cmd.ch);

    // Shared unit: one channel per cycle, update and running minimum.
    always_comb
    begin
        cur_val = period_reg ? staged_reg[idx_reg] : active_reg[idx_reg];
        if (period_reg)
        begin
            kill    = (cur_val == DUTY_OFF);
            pin_val = !kill;
        end
        else
        begin
            kill    = (cur_val == cmp_reg);
            pin_val = pins_reg[idx_reg] && !kill;
        end
        new_val  = kill ? NO_MATCH : cur_val;
        scan_min = (new_val < min_reg) ? new_val : min_reg;
    end

    assign ready     = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res.pins  = pins_reg;
    assign res.cmp   = cmp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pins_reg   <= '0;
            cmp_reg    <= NO_MATCH;
            min_reg    <= NO_MATCH;
            idx_reg    <= '0;
            period_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                staged_reg[i] <= DUTY_OFF;
                active_reg[i] <= NO_MATCH;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        idx_reg <= '0;
                        min_reg <= NO_MATCH;
                        case (cmd.op)
                            OP_WRITE:
                            begin
                                if (32'(cmd.ch) < ACT_CH)
                                begin
                                    staged_reg[wr_idx] <= cmd.duty;
                                end
                                state_reg <= ST_DONE;
                            end
                            OP_PERIOD:
                            begin
                                case (mode)
                                    MODE_BREATH: staged_reg[ACT_CH] <= breath_level;
                                    MODE_ON:     staged_reg[ACT_CH] <= NO_MATCH;
                                    default:     staged_reg[ACT_CH] <= DUTY_OFF;
                                endcase
                                period_reg <= 1'b1;
                                state_reg  <= ST_SCAN;
                            end
                            OP_MATCH:
                            begin
                                period_reg <= 1'b0;
                                state_reg  <= (cmp_reg == NO_MATCH) ? ST_DONE : ST_SCAN;
                            end
                            default:
                            begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    active_reg[idx_reg] <= new_val;
                    pins_reg[idx_reg]   <= pin_val;
                    min_reg             <= scan_min;
                    if (idx_reg == IDXW'(CHANNELS - 1))
                    begin
                        cmp_reg   <= scan_min;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDXW'(1);
                    end
                end
                ST_DONE:
                begin
                    if (res_take)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ sv/multichannel_pwm_with_breathing_led.sv @@
// Top level: stream ports, mode register and result register of the PWM scheduler.
// Timing: a write, an idle event or a match with no compare point pending goes straight
//   to its result; a period start or any other compare match first walks all CHANNELS channels.
// The core takes no new event until its result has moved into the output register, and
//   the single compare/minimum unit walks one channel per cycle.
// Reset (rst_n, async, active low): outputs off, compare point 255, staged 0, mode 0.
`default_nettype none
module multichannel_pwm_with_breathing_led (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Mode register write channel: cfg_data = activity_mode
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [mpwm_pkg::MODE_W-1:0]     cfg_data,
    // Event stream in
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // s_tdata from bit 0 up: channel[3:0], duty_value[7:0], zero padding
    input  wire logic [mpwm_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: operation[1:0]
    input  wire logic [mpwm_pkg::OP_W-1:0]       s_tuser,
    // Result stream out
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata from bit 0 up: pin_levels[CHANNELS-1:0], compare_point[7:0], zero padding
    output logic [mpwm_pkg::M_TDATA_W-1:0]       m_tdata
);
    import mpwm_pkg::*;

    logic [MODE_W-1:0]    mode_reg;
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    cmd_t cmd;
    res_t res;
    logic core_ready;
    logic res_valid;
    logic res_take;
    logic start;

    // The mode register always takes a write; write it only with no event in flight.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_BREATH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= cfg_data;
        end
    end

    // Unpack the event; the operation rides in tuser.
    assign cmd.op   = s_tuser;
    assign cmd.ch   = s_tdata[CH_W-1:0];
    assign cmd.duty = s_tdata[CH_W+DUTY_W-1:CH_W];

    assign s_tready = core_ready;
    assign start    = s_tvalid && s_tready;

    mpwm_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .mode      (mode_reg),
        .ready     (core_ready),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    // Output register parts the two sides: the core may take the next event
    // while a finished result still waits for its transfer.
    assign res_take = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= res_valid;
        end
    end

    // Payload holds while stalled; no reset needed.
    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            out_data_reg <= M_TDATA_W'({res.cmp, res.pins});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // An accepted event keeps the input closed on the following cycle.
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready
    ) else $error("input ready right after an accepted event");

    // A pending compare point always belongs to a channel that is still on.
    a_cmp_has_pin: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[CHANNELS+DUTY_W-1:CHANNELS] != NO_MATCH))
            |-> (m_tdata[CHANNELS-1:0] != '0)
    ) else $error("compare point pending with every pin off");

    // A finished result that cannot move blocks new events.
    a_stall_blocks_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid && !res_take) |-> !s_tready
    ) else $error("event accepted while a result is stalled in the core");

endmodule
`default_nettype wire

@@ tb/sv/mpwm_checker.sv @@
// Scoreboard for the PWM scheduler: tracks the schedule, predicts every result and checks it.
module mpwm_checker
    import mpwm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [MODE_W-1:0]     cfg_data,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic [OP_W-1:0]       s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [M_TDATA_W-1:0]  m_tdata,
    output int                         fails,
    output int                         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [MODE_W-1:0]   mode_q;
    logic [DUTY_W-1:0]   staged [CHANNELS];
    logic [DUTY_W-1:0]   armed [CHANNELS];
    logic [DUTY_W-1:0]   compare_q;
    logic [DUTY_W-1:0]   breath_q;
    logic                falling_q;
    logic [CHANNELS-1:0] pins_q;
    res_t                levels_due [$];

    function automatic logic [DUTY_W-1:0] earliest_turnoff();
        logic [DUTY_W-1:0] low;
        low = NO_MATCH;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (armed[i] < low)
                low = armed[i];
        end
        return low;
    endfunction

    task automatic clear_schedule();
        mode_q    = MODE_BREATH;
        compare_q = NO_MATCH;
        breath_q  = '0;
        falling_q = 1'b0;
        pins_q    = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            staged[i] = DUTY_OFF;
            armed[i]  = NO_MATCH;
        end
        levels_due.delete();
    endtask

    task automatic advance_schedule(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                                    input logic [DUTY_W-1:0] duty);
        res_t due;
        case (op)
            OP_WRITE:
            begin
                if (ch < ACT_CH)
                    staged[ch] = duty;
            end
            OP_PERIOD:
            begin
                if (mode_q == MODE_BREATH)
                begin
                    staged[ACT_CH] = (breath_q > BREATH_DARK) ? breath_q : DUTY_OFF;
                    breath_q = falling_q ? breath_q - 8'd1 : breath_q + 8'd1;
                    if (breath_q >= BREATH_TOP)
                        falling_q = 1'b1;
                    else if (breath_q <= BREATH_BOTTOM)
                        falling_q = 1'b0;
                end
                else if (mode_q == MODE_ON)
                    staged[ACT_CH] = {DUTY_W{1'b1}};
                else
                    staged[ACT_CH] = DUTY_OFF;
                for (int i = 0; i < CHANNELS; i++)
                begin
                    pins_q[i] = (staged[i] != DUTY_OFF);
                    armed[i]  = (staged[i] != DUTY_OFF) ? staged[i] : NO_MATCH;
                end
                compare_q = earliest_turnoff();
            end
            OP_MATCH:
            begin
                if (compare_q != NO_MATCH)
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        if (armed[i] == compare_q)
                        begin
                            pins_q[i] = 1'b0;
                            armed[i]  = NO_MATCH;
                        end
                    end
                    compare_q = earliest_turnoff();
                end
            end
            default: ;
        endcase
        due.pins = pins_q;
        due.cmp  = compare_q;
        levels_due.push_back(due);
    endtask

    always @(posedge clk)
    begin : watch
        res_t seen;
        res_t want;
        if (!rst_n)
            clear_schedule();
        else
        begin
            // results pass the core and then the output register after their event, so retire first
            if (m_tvalid && m_tready)
            begin
                seen.pins = m_tdata[CHANNELS-1:0];
                seen.cmp  = m_tdata[CHANNELS +: DUTY_W];
                if (levels_due.size() == 0)
                begin
                    $error("unexpected result: pin_levels %h compare_point %0d",
                           seen.pins, seen.cmp);
                    fails++;
                end
                else
                begin
                    want = levels_due.pop_front();
                    if (seen.pins !== want.pins)
                    begin
                        $error("pin_levels: expected %h, actual %h", want.pins, seen.pins);
                        fails++;
                    end
                    if (seen.cmp !== want.cmp)
                    begin
                        $error("compare_point: expected %0d, actual %0d", want.cmp, seen.cmp);
                        fails++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                mode_q = cfg_data;
            if (s_tvalid && s_tready)
                advance_schedule(s_tuser, s_tdata[CH_W-1:0], s_tdata[CH_W +: DUTY_W]);
        end
        outstanding = levels_due.size();
    end

endmodule

@@ tb/sv/multichannel_pwm_with_breathing_led_tb.sv @@
// Testbench top for the PWM scheduler: drives events and mode writes, gives the verdict.
module multichannel_pwm_with_breathing_led_tb import mpwm_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // Stimulus stops once this many events that touch the schedule were accepted.
    localparam int ITEMS  = 1350;
    // Sweep events, mostly period starts in breathing mode, enough to turn the ramp at both ends.
    localparam int SWEEP  = 640;
    // Cycle budget, several times the slowest legal run.
    localparam int LIMIT  = 1_000_000;
    // Longest event latency (a scan) plus margin.
    localparam int SETTLE = CHANNELS + 4;

    // Codes the package leaves unnamed.
    localparam logic [OP_W-1:0]   OP_NONE    = 2'd3;
    localparam logic [MODE_W-1:0] MODE_OFF   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [MODE_W-1:0]    cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [OP_W-1:0]      s_tuser   = '0;
    logic                 m_tready  = 1'b0;
    logic                 cfg_ready;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;

    int          fails;
    int          outstanding;
    int          events_sent = 0;
    int          cycle_cnt   = 0;
    bit          calm        = 1'b0;
    int unsigned ready_hold  = 0;

    multichannel_pwm_with_breathing_led u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mpwm_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fails      (fails),
        .outstanding(outstanding)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Favor off, full-on, the ends of the range and a narrow band that produces ties.
    function automatic logic [DUTY_W-1:0] pick_duty();
        case ($urandom_range(0, 9))
            0, 1:    return DUTY_OFF;
            2:       return {DUTY_W{1'b1}};
            3:       return DUTY_W'($urandom_range(1, 3));
            4:       return DUTY_W'($urandom_range(250, 254));
            5:       return DUTY_W'($urandom_range(40, 43));
            default: return DUTY_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly user channels; now and then the activity channel or beyond, which is dropped.
    function automatic logic [CH_W-1:0] pick_channel();
        if ($urandom_range(0, 19) == 0)
            return CH_W'($urandom_range(ACT_CH, (1 << CH_W) - 1));
        return CH_W'($urandom_range(0, ACT_CH - 1));
    endfunction

    // Result side: hold tready for a random stretch, or keep it high in calm phases.
    always @(posedge clk)
    begin
        if (calm)
        begin
            m_tready   <= 1'b1;
            ready_hold <= 0;
        end
        else if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            m_tready   <= ($urandom_range(0, 2) != 0);
            ready_hold <= pick_gap();
        end
    end

    // Present one event and hold it until the transfer. Lower tvalid only when a gap
    // follows, so back-to-back events keep it high without a second assignment.
    task automatic send_event(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                              input logic [DUTY_W-1:0] duty);
        int unsigned gap;
        gap = calm ? 0 : pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({duty, ch});
        do @(posedge clk); while (!s_tready);
        // dropped writes and the unused operation leave the schedule alone
        if (!(op == OP_NONE || (op == OP_WRITE && ch >= ACT_CH)))
            events_sent++;
    endtask

    // Drop tvalid, wait for every expected result, then let any scan finish.
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Change the activity mode only with the block idle.
    task automatic write_mode(input logic [MODE_W-1:0] mode);
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // One PWM period: stage some duties, start the period, then walk the compare points.
    // Too few matches leaves channels on into the next period; extra ones hit 255.
    task automatic run_frame();
        int unsigned n_writes;
        int unsigned n_matches;
        n_writes  = $urandom_range(0, 6);
        n_matches = $urandom_range(0, 13);
        repeat (n_writes) send_event(OP_WRITE, pick_channel(), pick_duty());
        send_event(OP_PERIOD, CH_W'($urandom), DUTY_W'($urandom));
        repeat (n_matches)
        begin
            // stage a value for the next period in the middle of this one
            if ($urandom_range(0, 7) == 0)
                send_event(OP_WRITE, pick_channel(), pick_duty());
            send_event(OP_MATCH, CH_W'($urandom), DUTY_W'($urandom));
        end
    endtask

    initial
    begin : stimulus
        int unsigned r;
        logic [MODE_W-1:0] mode;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, breathing mode from reset.
        send_event(OP_MATCH, 4'h0, 8'h00);     // compare match with nothing pending
        send_event(OP_NONE, 4'hF, 8'hFF);      // unused operation
        send_event(OP_WRITE, 4'd0, 8'd255);    // on for the whole period
        send_event(OP_WRITE, 4'd1, 8'd1);
        send_event(OP_WRITE, 4'd2, 8'd0);
        send_event(OP_WRITE, 4'd3, 8'd50);     // two channels sharing a compare point
        send_event(OP_WRITE, 4'd4, 8'd50);
        send_event(OP_WRITE, 4'd9, 8'd128);
        send_event(OP_WRITE, CH_W'(ACT_CH), 8'd77);  // activity channel: dropped
        send_event(OP_WRITE, 4'hF, 8'hAA);     // beyond the channels: dropped
        send_event(OP_PERIOD, 4'h0, 8'h00);
        repeat (4) send_event(OP_MATCH, 4'h0, 8'h00);
        send_event(OP_NONE, 4'h0, 8'h00);
        write_mode(MODE_ON);
        send_event(OP_PERIOD, 4'h5, 8'h55);
        send_event(OP_MATCH, 4'hA, 8'hAA);
        write_mode(MODE_OFF);
        send_event(OP_PERIOD, 4'h0, 8'h00);
        write_mode(MODE_SPARE);                // unused mode behaves as off
        send_event(OP_PERIOD, 4'hF, 8'hFF);

        // Ramp sweep: mostly period starts so the breathing level turns at the top
        // and again at the bottom.
        calm <= 1'b0;
        write_mode(MODE_BREATH);
        repeat (SWEEP)
        begin
            r = $urandom_range(0, 19);
            if (r < 2)
                send_event(OP_WRITE, pick_channel(), pick_duty());
            else if (r == 2)
                send_event(OP_MATCH, CH_W'($urandom), DUTY_W'($urandom));
            else
                send_event(OP_PERIOD, CH_W'($urandom), DUTY_W'($urandom));
        end

        // Phases of frames, each under a fresh mode; breathing gets the most weight.
        while (events_sent < ITEMS)
        begin
            r = $urandom_range(0, 9);
            if (r < 6)
                mode = MODE_BREATH;
            else if (r < 8)
                mode = MODE_ON;
            else if (r == 8)
                mode = MODE_OFF;
            else
                mode = MODE_SPARE;
            calm <= ($urandom_range(0, 3) == 0);
            write_mode(mode);
            repeat ($urandom_range(3, 10))
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // noise: any operation, any channel, any duty
                    repeat ($urandom_range(1, 4))
                        send_event(OP_W'($urandom_range(0, 3)),
                                   CH_W'($urandom_range(0, 15)), DUTY_W'($urandom));
                end
                else
                    run_frame();
            end
        end

        // Drain and watch a while longer for stray results.
        wait_quiet();
        repeat (2 * SETTLE) @(posedge clk);
        if (fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
